// ===== hdl/swis_pkg.sv =====
// ----------------------------------------------------------------------------
// swis_pkg
// Shared types and constants for the stack with in-place insertion sort.
// ----------------------------------------------------------------------------
package swis_pkg;

   localparam int DATA_W   = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [KIND_W-1:0] {
      REQ_PUSH = 2'd0,
      REQ_POP  = 2'd1,
      REQ_SORT = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       push;        // write request word at top, count up
      logic       pop;         // read top entry, count down
      logic       sort_start;  // outer index to one, read entry one
      logic       key_load;    // capture key, inner index from outer, read below it
      logic       shift;       // move compared entry up one, inner index down
      logic       place;       // drop key at inner index, advance outer index
      logic       rsp_load;    // fill the response register
      logic       rsp_pop;     // response word from read data, else zero
      status_type rsp_status;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic empty;     // no entries held
      logic full;      // all entries held
      logic few;       // fewer than two entries, nothing to sort
      logic key_less;  // key below the entry just read
      logic k_one;     // inner index at one, next slot is the bottom
      logic i_last;    // current outer index is the last held entry
      logic rsp_free;  // response register can take a new transaction
   } stat_type;

endpackage

// ===== hdl/swis_req_if.sv =====
// ----------------------------------------------------------------------------
// swis_req_if
// Request channel: valid/ready handshake with request kind and push word.
// ----------------------------------------------------------------------------
interface swis_req_if;

   logic                                valid;
   logic                                ready;
   logic [swis_pkg::KIND_W-1:0]         req_type;
   logic signed [swis_pkg::DATA_W-1:0]  push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);

endinterface

// ===== hdl/swis_rsp_if.sv =====
// ----------------------------------------------------------------------------
// swis_rsp_if
// Response channel: valid/ready handshake with popped word, status and count.
// ----------------------------------------------------------------------------
interface swis_rsp_if;

   logic                                valid;
   logic                                ready;
   logic signed [swis_pkg::DATA_W-1:0]  pop_value;
   logic [swis_pkg::STATUS_W-1:0]       status;
   logic [swis_pkg::COUNT_W-1:0]        count;

   modport source (output valid, output pop_value, output status, output count,
                   input ready);
   modport sink   (input valid, input pop_value, input status, input count,
                   output ready);

endinterface

// ===== hdl/swis_ram.sv =====
// ----------------------------------------------------------------------------
// swis_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/swis_datapath.sv =====
// ----------------------------------------------------------------------------
// swis_datapath
// Entry store, entry count, sort indexes and key, and the response register.
// ----------------------------------------------------------------------------
module swis_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  swis_pkg::cmd_type                   cmd,
   output swis_pkg::stat_type                  stat,
   input  logic signed [swis_pkg::DATA_W-1:0]  push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [swis_pkg::DATA_W-1:0]  rsp_pop_value,
   output logic [swis_pkg::STATUS_W-1:0]       rsp_status,
   output logic [swis_pkg::COUNT_W-1:0]        rsp_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = swis_pkg::DATA_W;

   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          i_ff, i_in;
   logic [AW-1:0]          k_ff, k_in;
   logic signed [DW-1:0]   key_ff, key_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]   rsp_pop_value_ff, rsp_pop_value_in;
   logic [swis_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [swis_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                   wr_en, rd_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [DW-1:0]          wr_data, rd_data;
   logic [CW-1:0]          count_dec, i_next_cnt;

   assign count_dec  = count_ff - CW'(1);
   assign i_next_cnt = CW'(i_ff) + CW'(1);

   always_comb begin
      stat.empty    = (count_ff == '0);
      stat.full     = (count_ff >= CW'(DEPTH));
      stat.few      = (count_ff < CW'(2));
      stat.key_less = (key_ff < $signed(rd_data));
      stat.k_one    = (k_ff == AW'(1));
      stat.i_last   = (i_next_cnt == count_ff);
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   // store port selection
   always_comb begin
      wr_en   = cmd.push | cmd.shift | cmd.place;
      wr_addr = cmd.push ? count_ff[AW-1:0] : k_ff;
      wr_data = cmd.push ? push_value : (cmd.shift ? rd_data : key_ff);

      rd_en   = cmd.pop | cmd.sort_start | cmd.key_load
              | (cmd.shift & !stat.k_one) | (cmd.place & !stat.i_last);
      if (cmd.pop) begin
         rd_addr = count_dec[AW-1:0];
      end else if (cmd.sort_start) begin
         rd_addr = AW'(1);
      end else if (cmd.key_load) begin
         rd_addr = i_ff - AW'(1);
      end else if (cmd.shift) begin
         rd_addr = k_ff - AW'(2);
      end else begin
         rd_addr = i_ff + AW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      key_in   = key_ff;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_dec;
      end
      if (cmd.sort_start) begin
         i_in = AW'(1);
      end else if (cmd.place) begin
         i_in = i_ff + AW'(1);
      end
      if (cmd.key_load) begin
         key_in = $signed(rd_data);
         k_in   = i_ff;
      end else if (cmd.shift) begin
         k_in = k_ff - AW'(1);
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_pop_value_in = rsp_pop_value_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_count_in     = rsp_count_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in     = 1'b1;
         rsp_pop_value_in = cmd.rsp_pop ? $signed(rd_data) : '0;
         rsp_status_in    = cmd.rsp_status;
         rsp_count_in     = swis_pkg::COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff             <= i_in;
      k_ff             <= k_in;
      key_ff           <= key_in;
      rsp_pop_value_ff <= rsp_pop_value_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_count_ff     <= rsp_count_in;
   end

   swis_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = rsp_pop_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;

endmodule

// ===== hdl/swis_ctrl.sv =====
// ----------------------------------------------------------------------------
// swis_ctrl
// Request sequencer: decodes requests and steps the insertion sort.
// ----------------------------------------------------------------------------
module swis_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [swis_pkg::KIND_W-1:0]   req_type,
   output logic                          req_ready,
   input  swis_pkg::stat_type            stat,
   output swis_pkg::cmd_type             cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_POP   = 5'b00010,
      S_KEY   = 5'b00100,
      S_CMP   = 5'b01000,
      S_PLACE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && stat.rsp_free;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = swis_pkg::ST_DONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_type)
                  swis_pkg::REQ_PUSH: begin
                     cmd.rsp_load = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_status = swis_pkg::ST_FULL;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  swis_pkg::REQ_POP: begin
                     if (stat.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = swis_pkg::ST_EMPTY;
                     end else begin
                        cmd.pop  = 1'b1;
                        state_in = S_POP;
                     end
                  end
                  swis_pkg::REQ_SORT: begin
                     if (stat.few) begin
                        cmd.rsp_load = 1'b1;
                     end else begin
                        cmd.sort_start = 1'b1;
                        state_in       = S_KEY;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_pop  = 1'b1;
            state_in     = S_IDLE;
         end
         S_KEY: begin
            cmd.key_load = 1'b1;
            state_in     = S_CMP;
         end
         S_CMP: begin
            if (stat.key_less) begin
               cmd.shift = 1'b1;
               // bottom reached: the key goes into slot zero next cycle
               state_in  = stat.k_one ? S_PLACE : S_CMP;
            end else begin
               cmd.place    = 1'b1;
               cmd.rsp_load = stat.i_last;
               state_in     = stat.i_last ? S_IDLE : S_KEY;
            end
         end
         S_PLACE: begin
            cmd.place    = 1'b1;
            cmd.rsp_load = stat.i_last;
            state_in     = stat.i_last ? S_IDLE : S_KEY;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/stack_with_insertion_sort.sv =====
// ----------------------------------------------------------------------------
// stack_with_insertion_sort
// LIFO stack of signed words with an in-place ascending insertion sort.
// ----------------------------------------------------------------------------
// Requests come in on req_chan (push, pop or sort), one response per request
// goes out on rsp_chan with the popped word, a status and the entry count.
// Entries live in a RAM with one write and one registered read port.
// Push, failed pop, sort of fewer than two entries and an unused kind are
// answered straight from the idle state; a pop of a held entry first reads
// the RAM. A sort takes each entry from slot one upward: it loads the key,
// shifts the larger entries below it up one slot each, then places the key,
// whether or not it lands in slot zero.
// The sort walks the store through the single RAM read port, one compare
// per cycle. A new request is taken only after the previous one finishes.
// The response register holds its transaction while rsp_chan.ready is low;
// req_chan.ready stays low until it can be replaced, so nothing is lost.
// Synchronous reset empties the stack and drops any pending response; the
// stored words are not cleared and are never read before being pushed.
// ----------------------------------------------------------------------------
module stack_with_insertion_sort #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   swis_req_if.sink          req_chan,
   swis_rsp_if.source        rsp_chan
);

   swis_pkg::cmd_type  cmd;
   swis_pkg::stat_type stat;

   swis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   swis_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .push_value    (req_chan.push_value),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_pop_value (rsp_chan.pop_value),
      .rsp_status    (rsp_chan.status),
      .rsp_count     (rsp_chan.count)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stack with in-place insertion sort.
// ----------------------------------------------------------------------------
// A queue of requests is built up front: a short directed run over the empty,
// single-entry and full cases and the word extremes, then random runs that
// lean toward filling or draining the stack. A clocked driver feeds them in
// with random gaps, a shadow stack predicts each response, and a clocked
// monitor checks every response under random back-pressure, including one
// long hold-off that fills the block and stalls its request side.
// ----------------------------------------------------------------------------
module testbench;

   import swis_pkg::*;

   localparam int               STACK_DEPTH  = 16;
   localparam int               RANDOM_ITEMS = 1500;
   localparam int               CALM_ITEMS   = 200;
   localparam int               REPORT_LIMIT = 100;
   localparam logic [KIND_W-1:0] REQ_UNUSED  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] value;
   } stack_req_t;

   typedef struct packed {
      logic signed [DATA_W-1:0] pop_value;
      status_type               status;
      logic [COUNT_W-1:0]       count;
   } stack_rsp_t;

   logic clock;
   logic reset;

   swis_req_if req_bus ();
   swis_rsp_if rsp_bus ();

   stack_with_insertion_sort #(
      .DEPTH (STACK_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // requests not yet taken by the block, responses the block still owes
   stack_req_t req_backlog[$];
   stack_rsp_t owed_responses[$];

   // shadow copy of the stack
   logic signed [DATA_W-1:0] shadow_words [STACK_DEPTH];
   int unsigned              shadow_held;

   int unsigned accepted;
   int unsigned calm_from;
   bit          req_taken;
   int unsigned send_gap;
   int unsigned stall_left;
   int unsigned hold_left;
   bit          holdoff_done;
   int unsigned failures;
   int unsigned checked;
   int unsigned n_push, n_pop, n_sort, n_unused, n_full_drop, n_empty_pop, sort_peak;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("timeout at %0t with %0d requests waiting, %0d responses owed",
               $time, req_backlog.size(), owed_responses.size());
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic stack_rsp_t stack_apply(stack_req_t r);
      stack_rsp_t               res;
      logic signed [DATA_W-1:0] key;
      int                       k;
      res.pop_value = '0;
      res.status    = ST_DONE;
      case (r.kind)
         REQ_PUSH: begin
            n_push++;
            if (shadow_held >= STACK_DEPTH) begin
               res.status = ST_FULL;
               n_full_drop++;
            end else begin
               shadow_words[shadow_held] = r.value;
               shadow_held++;
            end
         end
         REQ_POP: begin
            n_pop++;
            if (shadow_held == 0) begin
               res.status = ST_EMPTY;
               n_empty_pop++;
            end else begin
               shadow_held--;
               res.pop_value = shadow_words[shadow_held];
            end
         end
         REQ_SORT: begin
            n_sort++;
            if (shadow_held > sort_peak) sort_peak = shadow_held;
            // stable: only strictly larger entries are passed over
            for (int i = 1; i < shadow_held; i++) begin
               key = shadow_words[i];
               k   = i;
               while (k >= 1 && key < shadow_words[k-1]) begin
                  shadow_words[k] = shadow_words[k-1];
                  k--;
               end
               shadow_words[k] = key;
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      res.count = COUNT_W'(shadow_held);
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic queue_req(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value);
      stack_req_t r;
      r.kind  = kind;
      r.value = value;
      req_backlog.push_back(r);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return -32'sd1;
         3, 4:    return DATA_W'($urandom_range(0, 15)) - 32'd8;  // near-duplicates
         default: return $urandom;
      endcase
   endfunction

   task automatic build_random_part();
      int unsigned made;
      int unsigned run_len;
      int unsigned push_pct;
      int unsigned roll;
      made = 0;
      while (made < RANDOM_ITEMS) begin
         run_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0:       push_pct = 65;  // fill toward full
            1:       push_pct = 25;  // drain toward empty
            default: push_pct = 42;
         endcase
         for (int j = 0; j < run_len && made < RANDOM_ITEMS; j++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)                  queue_req(REQ_UNUSED, pick_word());
            else if (roll < 15)            queue_req(REQ_SORT, pick_word());
            else if (roll < 15 + push_pct) queue_req(REQ_PUSH, pick_word());
            else                           queue_req(REQ_POP, pick_word());
            made++;
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_PUSH;
      req_bus.push_value = '0;
      rsp_bus.ready      = 1'b0;
      shadow_held        = 0;
      accepted           = 0;
      req_taken          = 1'b0;
      send_gap           = 0;
      stall_left         = 0;
      hold_left          = 0;
      holdoff_done       = 1'b0;
      failures           = 0;
      checked            = 0;
      n_push = 0; n_pop = 0; n_sort = 0; n_unused = 0;
      n_full_drop = 0; n_empty_pop = 0; sort_peak = 0;

      // empty stack corner cases, then a single entry
      queue_req(REQ_POP,    32'sd0);
      queue_req(REQ_SORT,   32'sd0);
      queue_req(REQ_UNUSED, 32'sh5A5A_A5A5);
      queue_req(REQ_PUSH,   32'sh7FFF_FFFF);
      queue_req(REQ_SORT,   32'sd0);
      // fill with extremes and repeated keys
      queue_req(REQ_PUSH,   32'sh8000_0000);
      queue_req(REQ_PUSH,   -32'sd1);
      queue_req(REQ_PUSH,   32'sd0);
      queue_req(REQ_PUSH,   32'sd1);
      queue_req(REQ_PUSH,   -32'sd1);
      queue_req(REQ_PUSH,   32'sd5);
      queue_req(REQ_PUSH,   32'sd5);
      queue_req(REQ_PUSH,   32'sh8000_0000);
      queue_req(REQ_PUSH,   32'sh7FFF_FFFF);
      queue_req(REQ_PUSH,   32'sd3);
      queue_req(REQ_PUSH,   -32'sd7);
      queue_req(REQ_PUSH,   32'sd100);
      queue_req(REQ_PUSH,   -32'sd100);
      queue_req(REQ_PUSH,   32'sd0);
      queue_req(REQ_PUSH,   32'sd2);
      // stack is full now
      queue_req(REQ_PUSH,   32'sd12345);
      queue_req(REQ_SORT,   32'sd0);
      queue_req(REQ_UNUSED, 32'sd0);
      queue_req(REQ_POP,    32'sd0);
      queue_req(REQ_POP,    32'sd0);

      build_random_part();
      calm_from = req_backlog.size() - CALM_ITEMS;

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (req_backlog.size() > 0 || owed_responses.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d requests: %0d push (%0d dropped full), %0d pop (%0d on empty)",
               accepted, n_push, n_full_drop, n_pop, n_empty_pop);
      $display("  %0d sorts (up to %0d entries), %0d unused kind, %0d responses checked",
               n_sort, sort_peak, n_unused, checked);
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatching responses", failures);
         $display("end of test: mismatches");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      stack_req_t taken;
      if (!reset && req_bus.valid && req_bus.ready) begin
         taken.kind  = req_bus.req_type;
         taken.value = req_bus.push_value;
         owed_responses.push_back(stack_apply(taken));
         void'(req_backlog.pop_front());
         accepted++;
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         req_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (accepted < calm_from && hold_left == 0 &&
                      $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 17) - 1;
            req_bus.valid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            req_bus.valid      <= 1'b1;
            req_bus.req_type   <= req_backlog[0].kind;
            req_bus.push_value <= req_backlog[0].value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         // one long hold-off so the block backs up into the request side
         if (!holdoff_done && accepted >= 120) begin
            hold_left    = 90;
            holdoff_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (accepted < calm_from && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      stack_rsp_t want;
      bit         bad;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (owed_responses.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: unexpected transaction: pop_value %0d status %0d count %0d",
                        $time, rsp_bus.pop_value, rsp_bus.status, rsp_bus.count);
         end else begin
            want = owed_responses.pop_front();
            checked++;
            bad  = 1'b0;
            if (rsp_bus.pop_value !== want.pop_value) begin
               bad = 1'b1;
               if (failures < REPORT_LIMIT)
                  $display("%0t: pop_value expected %0d, got %0d",
                           $time, want.pop_value, rsp_bus.pop_value);
            end
            if (rsp_bus.status !== want.status) begin
               bad = 1'b1;
               if (failures < REPORT_LIMIT)
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_bus.status);
            end
            if (rsp_bus.count !== want.count) begin
               bad = 1'b1;
               if (failures < REPORT_LIMIT)
                  $display("%0t: count expected %0d, got %0d",
                           $time, want.count, rsp_bus.count);
            end
            if (bad) failures++;
         end
      end
   end

endmodule

// ===== filelist.f =====
hdl/swis_pkg.sv
hdl/swis_req_if.sv
hdl/swis_rsp_if.sv
hdl/swis_ram.sv
hdl/swis_datapath.sv
hdl/swis_ctrl.sv
hdl/stack_with_insertion_sort.sv
tb/testbench.sv
